>>> rtl/core/lsh_pkg.sv
// ----------------------------------------------------------------------------
// lsh_pkg: shared types and codes for the Laplacian stencil core
// Holds the function codes of the request channel and the command record that
// travels from the front end through the queue into the execution back end.
// ----------------------------------------------------------------------------
`default_nettype none

package lsh_pkg;

   // Request function codes.
   localparam logic [1:0] FUNC_LOAD_GRID = 2'd0;
   localparam logic [1:0] FUNC_LOAD_HALO = 2'd1;
   localparam logic [1:0] FUNC_QUERY     = 2'd2;

   // Halo sides.
   localparam logic [1:0] SIDE_PLUS_X  = 2'd0;
   localparam logic [1:0] SIDE_MINUS_X = 2'd1;
   localparam logic [1:0] SIDE_PLUS_Y  = 2'd2;
   localparam logic [1:0] SIDE_MINUS_Y = 2'd3;

   // Field widths fixed by the request format.
   localparam int COORD_W  = 6;
   localparam int SAMPLE_W = 32;

   // Depth of the command queue between front and back end.
   localparam int QUEUE_DEPTH = 2;

   // Classified command kinds.
   typedef enum logic [1:0] {
      CMD_GRID_WR,
      CMD_HALO_WR,
      CMD_QUERY
   } cmd_kind_type;

   // One classified command.
   typedef struct packed {
      cmd_kind_type               kind;
      logic [COORD_W-1:0]         col;
      logic [COORD_W-1:0]         row;
      logic [1:0]                 side;
      logic [COORD_W-1:0]         pos;
      logic signed [SAMPLE_W-1:0] sample;
   } cmd_type;

   // Back end status, visible to the top level.
   typedef struct packed {
      logic inflight;
      logic reading;
   } back_status_type;

endpackage

`default_nettype wire

>>> rtl/core/lsh_front.sv
// ----------------------------------------------------------------------------
// lsh_front: request intake and classification
// Accepts request transfers, drops those that fall outside the tile or use an
// unused function code, and registers the rest as commands for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lsh_front #(
   parameter int GRID_X = 64,
   parameter int GRID_Y = 64
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [1:0]                   req_func,
   input  wire logic [lsh_pkg::COORD_W-1:0]  req_col,
   input  wire logic [lsh_pkg::COORD_W-1:0]  req_row,
   input  wire logic [1:0]                   req_direction,
   input  wire logic [lsh_pkg::COORD_W-1:0]  req_halo_index,
   input  wire logic signed [lsh_pkg::SAMPLE_W-1:0] req_sample,
   output logic                              push_valid,
   output lsh_pkg::cmd_type                  push_cmd,
   input  wire logic                         push_ready
);
   import lsh_pkg::*;

   logic    cmd_valid_ff, cmd_valid_in;
   cmd_type cmd_ff, cmd_in;
   logic    accept;
   logic    in_tile;
   logic    halo_ok;
   logic    keep;

   // The holding register frees up whenever the queue takes its command.
   assign req_stall = cmd_valid_ff && !push_ready;
   assign accept    = req_valid && !req_stall;

   // Classification of the incoming request.
   always_comb begin
      in_tile = (32'(req_col) < 32'(GRID_X)) && (32'(req_row) < 32'(GRID_Y));
      if (req_direction == SIDE_PLUS_X || req_direction == SIDE_MINUS_X) begin
         halo_ok = 32'(req_halo_index) < 32'(GRID_Y);
      end else begin
         halo_ok = 32'(req_halo_index) < 32'(GRID_X);
      end
      cmd_in.col    = req_col;
      cmd_in.row    = req_row;
      cmd_in.side   = req_direction;
      cmd_in.pos    = req_halo_index;
      cmd_in.sample = req_sample;
      case (req_func)
         FUNC_LOAD_GRID: begin
            cmd_in.kind = CMD_GRID_WR;
            keep        = in_tile;
         end
         FUNC_LOAD_HALO: begin
            cmd_in.kind = CMD_HALO_WR;
            keep        = halo_ok;
         end
         FUNC_QUERY: begin
            cmd_in.kind = CMD_QUERY;
            keep        = in_tile;
         end
         default: begin
            cmd_in.kind = CMD_QUERY;
            keep        = 1'b0;
         end
      endcase
   end

   // Next state of the holding register.
   always_comb begin
      if (accept) begin
         cmd_valid_in = keep;
      end else if (push_ready) begin
         cmd_valid_in = 1'b0;
      end else begin
         cmd_valid_in = cmd_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
      end else begin
         cmd_valid_ff <= cmd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= cmd_in;
      end
   end

   assign push_valid = cmd_valid_ff;
   assign push_cmd   = cmd_ff;

endmodule

`default_nettype wire

>>> rtl/core/lsh_queue.sv
// ----------------------------------------------------------------------------
// lsh_queue: command queue between front and back end
// A short first-in first-out buffer that lets intake and execution stall
// independently of each other.
// ----------------------------------------------------------------------------
`default_nettype none

module lsh_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   input  wire lsh_pkg::cmd_type push_cmd,
   output logic                  push_ready,
   output logic                  pop_valid,
   output lsh_pkg::cmd_type      pop_cmd,
   input  wire logic             pop_take
);
   import lsh_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign push_ready = count_ff != CNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_take && pop_valid;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/lsh_back.sv
// ----------------------------------------------------------------------------
// lsh_back: command execution
// Owns the grid and halo memories. Each load writes one entry. A query reads
// the centre and four neighbours, each from the grid or the halo read port, one
// per cycle, and accumulates the stencil sum before saturating it.
// ----------------------------------------------------------------------------
`default_nettype none

module lsh_back #(
   parameter int GRID_X = 64,
   parameter int GRID_Y = 64
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic signed [lsh_pkg::SAMPLE_W-1:0] diag_gain,
   input  wire logic                         pop_valid,
   input  wire lsh_pkg::cmd_type             pop_cmd,
   output logic                              pop_take,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic signed [lsh_pkg::SAMPLE_W-1:0] rsp_stencil_value,
   output logic                              rsp_saturated,
   output lsh_pkg::back_status_type          status
);
   import lsh_pkg::*;

   localparam int HALO_SIDE  = (GRID_X > GRID_Y) ? GRID_X : GRID_Y;
   localparam int GRID_DEPTH = GRID_X * GRID_Y;
   localparam int HALO_DEPTH = 4 * HALO_SIDE;
   localparam int GA_W       = $clog2(GRID_DEPTH);
   localparam int HA_W       = $clog2(HALO_DEPTH);
   localparam int PROD_W     = 2 * SAMPLE_W;
   localparam int ACC_W      = PROD_W - 16 + 3;

   // Read steps of one query.
   localparam logic [2:0] STEP_CENTER  = 3'd0;
   localparam logic [2:0] STEP_PLUS_X  = 3'd1;
   localparam logic [2:0] STEP_MINUS_X = 3'd2;
   localparam logic [2:0] STEP_PLUS_Y  = 3'd3;
   localparam logic [2:0] STEP_MINUS_Y = 3'd4;

   typedef enum logic {
      S_IDLE,
      S_READ
   } state_type;

   state_type              state_ff;
   logic [2:0]             step_ff;
   logic [COORD_W-1:0]     qx_ff, qy_ff;

   logic signed [SAMPLE_W-1:0] grid_mem [GRID_DEPTH];
   logic signed [SAMPLE_W-1:0] halo_mem [HALO_DEPTH];
   logic signed [SAMPLE_W-1:0] grid_rdata_ff;
   logic signed [SAMPLE_W-1:0] halo_rdata_ff;

   logic                   a_valid_ff;
   logic [2:0]             a_step_ff;
   logic                   a_halo_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic                   done_ff;
   logic                   inflight_ff;
   logic                   rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] rsp_value_ff;
   logic                   rsp_sat_ff;

   logic                   start_query;
   logic                   grid_we, halo_we;
   logic [31:0]            grid_waddr_full, halo_waddr_full;
   logic [31:0]            grid_raddr_full, halo_raddr_full;
   logic [COORD_W:0]       rx, ry;
   logic [1:0]             rd_side;
   logic [COORD_W-1:0]     rd_pos;
   logic                   use_halo;
   logic                   at_px, at_mx, at_py, at_my;
   logic signed [SAMPLE_W-1:0] nb;
   logic signed [ACC_W-1:0]  nb_ext;
   logic signed [ACC_W-1:0]  head;
   logic                   rsp_load;
   logic                   acc_sat;
   logic signed [SAMPLE_W-1:0] acc_clamped;

   // Loads go when the sequencer is idle; a query also waits for the previous one.
   always_comb begin
      pop_take = 1'b0;
      if (pop_valid && state_ff == S_IDLE) begin
         pop_take = (pop_cmd.kind != CMD_QUERY) || !inflight_ff;
      end
   end

   assign start_query = pop_take && pop_cmd.kind == CMD_QUERY;
   assign grid_we     = pop_take && pop_cmd.kind == CMD_GRID_WR;
   assign halo_we     = pop_take && pop_cmd.kind == CMD_HALO_WR;

   // Write addresses of loads.
   assign grid_waddr_full = 32'(pop_cmd.row) * 32'(GRID_X) + 32'(pop_cmd.col);
   assign halo_waddr_full = 32'(pop_cmd.side) * 32'(HALO_SIDE) + 32'(pop_cmd.pos);

   // Neighbor selection for the current read step.
   always_comb begin
      at_px    = 32'(qx_ff) == 32'(GRID_X - 1);
      at_mx    = qx_ff == '0;
      at_py    = 32'(qy_ff) == 32'(GRID_Y - 1);
      at_my    = qy_ff == '0;
      rx       = {1'b0, qx_ff};
      ry       = {1'b0, qy_ff};
      rd_side  = SIDE_PLUS_X;
      rd_pos   = qy_ff;
      use_halo = 1'b0;
      case (step_ff)
         STEP_CENTER: begin
            use_halo = 1'b0;
         end
         STEP_PLUS_X: begin
            rd_side  = SIDE_PLUS_X;
            rd_pos   = qy_ff;
            use_halo = at_px;
            if (!at_px) begin
               rx = {1'b0, qx_ff} + 1'b1;
            end
         end
         STEP_MINUS_X: begin
            rd_side  = SIDE_MINUS_X;
            rd_pos   = qy_ff;
            use_halo = at_mx;
            if (!at_mx) begin
               rx = {1'b0, qx_ff} - 1'b1;
            end
         end
         STEP_PLUS_Y: begin
            rd_side  = SIDE_PLUS_Y;
            rd_pos   = qx_ff;
            use_halo = at_py;
            if (!at_py) begin
               ry = {1'b0, qy_ff} + 1'b1;
            end
         end
         STEP_MINUS_Y: begin
            rd_side  = SIDE_MINUS_Y;
            rd_pos   = qx_ff;
            use_halo = at_my;
            if (!at_my) begin
               ry = {1'b0, qy_ff} - 1'b1;
            end
         end
         default: begin
            use_halo = 1'b0;
         end
      endcase
      grid_raddr_full = 32'(ry) * 32'(GRID_X) + 32'(rx);
      halo_raddr_full = 32'(rd_side) * 32'(HALO_SIDE) + 32'(rd_pos);
   end

   // Grid memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (grid_we) begin
         grid_mem[grid_waddr_full[GA_W-1:0]] <= pop_cmd.sample;
      end
      grid_rdata_ff <= grid_mem[grid_raddr_full[GA_W-1:0]];
   end

   // Halo memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (halo_we) begin
         halo_mem[halo_waddr_full[HA_W-1:0]] <= pop_cmd.sample;
      end
      halo_rdata_ff <= halo_mem[halo_raddr_full[HA_W-1:0]];
   end

   // Read sequencer: five steps per query.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= STEP_CENTER;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (start_query) begin
                  state_ff <= S_READ;
                  step_ff  <= STEP_CENTER;
                  qx_ff    <= pop_cmd.col;
                  qy_ff    <= pop_cmd.row;
               end
            end
            S_READ: begin
               if (step_ff == STEP_MINUS_Y) begin
                  state_ff <= S_IDLE;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // Tag of the data that leaves the memories next cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= state_ff == S_READ;
      end
      a_step_ff <= step_ff;
      a_halo_ff <= use_halo;
   end

   // Neighbor value and the floored product, both sign extended.
   assign nb     = a_halo_ff ? halo_rdata_ff : grid_rdata_ff;
   assign nb_ext = {{(ACC_W - SAMPLE_W){nb[SAMPLE_W-1]}}, nb};
   assign head   = {{3{prod_ff[PROD_W-1]}}, prod_ff[PROD_W-1:16]};

   // Product of the centre, then subtraction of the four neighbors.
   always_ff @(posedge clock) begin
      if (a_valid_ff && a_step_ff == STEP_CENTER) begin
         prod_ff <= diag_gain * grid_rdata_ff;
      end
      if (a_valid_ff && a_step_ff == STEP_PLUS_X) begin
         acc_ff <= head - nb_ext;
      end else if (a_valid_ff && a_step_ff != STEP_CENTER) begin
         acc_ff <= acc_ff - nb_ext;
      end
   end

   // Saturation to the 32-bit result range.
   always_comb begin
      acc_sat = !((acc_ff[ACC_W-1:SAMPLE_W-1] == '0) ||
                  (acc_ff[ACC_W-1:SAMPLE_W-1] == '1));
      if (!acc_sat) begin
         acc_clamped = acc_ff[SAMPLE_W-1:0];
      end else if (acc_ff[ACC_W-1]) begin
         acc_clamped = {1'b1, {(SAMPLE_W - 1){1'b0}}};
      end else begin
         acc_clamped = {1'b0, {(SAMPLE_W - 1){1'b1}}};
      end
   end

   assign rsp_load = done_ff && (!rsp_valid_ff || !rsp_stall);

   // Query bookkeeping and the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff      <= 1'b0;
         inflight_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (a_valid_ff && a_step_ff == STEP_MINUS_Y) begin
            done_ff <= 1'b1;
         end else if (rsp_load) begin
            done_ff <= 1'b0;
         end
         if (start_query) begin
            inflight_ff <= 1'b1;
         end else if (rsp_load) begin
            inflight_ff <= 1'b0;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_value_ff <= acc_clamped;
         rsp_sat_ff   <= acc_sat;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_stencil_value = rsp_value_ff;
   assign rsp_saturated     = rsp_sat_ff;
   assign status.inflight   = inflight_ff;
   assign status.reading    = state_ff == S_READ;

endmodule

`default_nettype wire

>>> rtl/core/laplacian_stencil_with_halo_core.sv
// Queries do not overlap: a query starts its five reads of the center and neighbors
// only after the previous query's result has been loaded into the output register.
// Loads each write one entry in the back end but wait behind a query ahead of them.
// Reset: synchronous, clears control state and sets diag_gain to 4.0;
// the grid and halo memories are not cleared.
// ----------------------------------------------------------------------------
// laplacian_stencil_with_halo_core: five-point Laplacian on a tile with halo
// Front end classifies requests, a short queue decouples it from the back end
// that holds the tile and halo memories and evaluates stencil queries.
// ----------------------------------------------------------------------------
`default_nettype none

module laplacian_stencil_with_halo_core #(
   parameter int GRID_X = 64,
   parameter int GRID_Y = 64
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_write_enable,
   input  wire logic signed [lsh_pkg::SAMPLE_W-1:0] csr_write_data,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [1:0]                   req_func,
   input  wire logic [lsh_pkg::COORD_W-1:0]  req_col,
   input  wire logic [lsh_pkg::COORD_W-1:0]  req_row,
   input  wire logic [1:0]                   req_direction,
   input  wire logic [lsh_pkg::COORD_W-1:0]  req_halo_index,
   input  wire logic signed [lsh_pkg::SAMPLE_W-1:0] req_sample,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic signed [lsh_pkg::SAMPLE_W-1:0] rsp_stencil_value,
   output logic                              rsp_saturated
);
   import lsh_pkg::*;

   localparam logic signed [SAMPLE_W-1:0] DIAG_RESET = 32'sd262144;

   logic signed [SAMPLE_W-1:0] diag_gain_ff;
   logic            push_valid;
   cmd_type         push_cmd;
   logic            push_ready;
   logic            pop_valid;
   cmd_type         pop_cmd;
   logic            pop_take;
   back_status_type status;

   // Diagonal gain register.
   always_ff @(posedge clock) begin
      if (reset) begin
         diag_gain_ff <= DIAG_RESET;
      end else if (csr_write_enable) begin
         diag_gain_ff <= csr_write_data;
      end
   end

   lsh_front #(
      .GRID_X (GRID_X),
      .GRID_Y (GRID_Y)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_col        (req_col),
      .req_row        (req_row),
      .req_direction  (req_direction),
      .req_halo_index (req_halo_index),
      .req_sample     (req_sample),
      .push_valid     (push_valid),
      .push_cmd       (push_cmd),
      .push_ready     (push_ready)
   );

   lsh_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_cmd    (pop_cmd),
      .pop_take   (pop_take)
   );

   lsh_back #(
      .GRID_X (GRID_X),
      .GRID_Y (GRID_Y)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .diag_gain         (diag_gain_ff),
      .pop_valid         (pop_valid),
      .pop_cmd           (pop_cmd),
      .pop_take          (pop_take),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_stencil_value (rsp_stencil_value),
      .rsp_saturated     (rsp_saturated),
      .status            (status)
   );

   // A saturated result is always one of the two range limits.
   a_sat_limits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         rsp_stencil_value == 32'sh7fffffff || rsp_stencil_value == 32'sh80000000)
      else $error("saturated result is not a range limit");

   // Memory reads for a query happen only while that query is outstanding.
   a_read_inflight: assert property (@(posedge clock) disable iff (reset)
      status.reading |-> status.inflight)
      else $error("query read sequence without an outstanding query");

   // No result is offered right after reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered after reset");

   // A query's reads start only when no earlier query was outstanding.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      $rose(status.reading) |-> $past(!status.inflight))
      else $error("query started while the previous one was outstanding");

endmodule

`default_nettype wire

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the five-point Laplacian stencil core
// Loads grid cells and halo entries, queries the stencil at cells whose
// center and neighbors were all loaded, and checks every result against a
// typed value or a shadow copy of the tile, the halo and the diagonal gain.
// A short table of directed items comes first. Random phases follow, each
// with its own gain and its own idling on the request and result channels.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

   import lsh_pkg::*;

   localparam int GRID_X    = 64;
   localparam int GRID_Y    = 64;
   localparam int HALO_SIDE = (GRID_X > GRID_Y) ? GRID_X : GRID_Y;
   localparam int SETTLE    = 24;
   localparam int QUIET_LIMIT = 2000;

   // Function code that the core ignores.
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   localparam logic signed [31:0] GAIN_RESET = 32'sd262144;
   localparam logic signed [31:0] SAMPLE_MAX = 32'sh7fffffff;
   localparam logic signed [31:0] SAMPLE_MIN = 32'sh80000000;

   typedef struct packed {
      logic [1:0]         func;
      logic [5:0]         col;
      logic [5:0]         row;
      logic [1:0]         direction;
      logic [5:0]         halo_index;
      logic signed [31:0] sample;
   } stencil_req_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic               sat;
   } stencil_result_type;

   typedef struct packed {
      stencil_req_type    req;
      bit                 typed;
      stencil_result_type result;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_write_enable;
   logic signed [31:0] csr_write_data;
   logic req_valid;
   logic req_stall;
   logic [1:0] req_func;
   logic [5:0] req_col;
   logic [5:0] req_row;
   logic [1:0] req_direction;
   logic [5:0] req_halo_index;
   logic signed [31:0] req_sample;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_stencil_value;
   logic rsp_saturated;

   // Shadow state of the core.
   logic signed [31:0] gain_shadow;
   logic signed [31:0] grid_shadow [GRID_X*GRID_Y];
   logic signed [31:0] halo_shadow [4*HALO_SIDE];
   bit grid_loaded [GRID_X*GRID_Y];
   bit halo_loaded [4*HALO_SIDE];

   stencil_result_type stencil_expected [$];
   stim_row_type directed_rows [$];

   int fail_count = 0;
   int quiet_cycles = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   laplacian_stencil_with_halo_core #(
      .GRID_X(GRID_X),
      .GRID_Y(GRID_Y)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_func(req_func),
      .req_col(req_col),
      .req_row(req_row),
      .req_direction(req_direction),
      .req_halo_index(req_halo_index),
      .req_sample(req_sample),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_stencil_value(rsp_stencil_value),
      .rsp_saturated(rsp_saturated)
   );

   // Clock with a period of 20.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int grid_at(input int x, input int y);
      return y * GRID_X + x;
   endfunction

   function automatic int halo_at(input int side, input int pos);
      return side * HALO_SIDE + pos;
   endfunction

   // Apply one accepted item to the shadow state; returns 1 with the stencil
   // result when the item is a query.
   function automatic bit stencil_eval(input stencil_req_type r,
                                       output stencil_result_type res);
      int x;
      int y;
      int side;
      int pos;
      longint acc;
      x = int'(r.col);
      y = int'(r.row);
      side = int'(r.direction);
      pos = int'(r.halo_index);
      res = '0;
      case (r.func)
         FUNC_LOAD_GRID: begin
            grid_shadow[grid_at(x, y)] = r.sample;
            grid_loaded[grid_at(x, y)] = 1'b1;
            return 1'b0;
         end
         FUNC_LOAD_HALO: begin
            halo_shadow[halo_at(side, pos)] = r.sample;
            halo_loaded[halo_at(side, pos)] = 1'b1;
            return 1'b0;
         end
         FUNC_QUERY: begin
            // The product keeps full width; the shift rounds toward minus infinity.
            acc = (longint'(gain_shadow) * longint'(grid_shadow[grid_at(x, y)])) >>> 16;
            acc -= (x == GRID_X - 1) ? longint'(halo_shadow[halo_at(SIDE_PLUS_X, y)])
                                     : longint'(grid_shadow[grid_at(x + 1, y)]);
            acc -= (x == 0) ? longint'(halo_shadow[halo_at(SIDE_MINUS_X, y)])
                            : longint'(grid_shadow[grid_at(x - 1, y)]);
            acc -= (y == GRID_Y - 1) ? longint'(halo_shadow[halo_at(SIDE_PLUS_Y, x)])
                                     : longint'(grid_shadow[grid_at(x, y + 1)]);
            acc -= (y == 0) ? longint'(halo_shadow[halo_at(SIDE_MINUS_Y, x)])
                            : longint'(grid_shadow[grid_at(x, y - 1)]);
            if (acc > longint'(SAMPLE_MAX)) begin
               res.value = SAMPLE_MAX;
               res.sat = 1'b1;
            end else if (acc < longint'(SAMPLE_MIN)) begin
               res.value = SAMPLE_MIN;
               res.sat = 1'b1;
            end else begin
               res.value = acc[31:0];
               res.sat = 1'b0;
            end
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   function automatic stim_row_type mk_row(input logic [1:0] f, input int c, input int r,
                                           input int d, input int i,
                                           input logic signed [31:0] s, input bit typed,
                                           input logic signed [31:0] v, input logic sat);
      stim_row_type row_item;
      row_item.req.func = f;
      row_item.req.col = 6'(c);
      row_item.req.row = 6'(r);
      row_item.req.direction = 2'(d);
      row_item.req.halo_index = 6'(i);
      row_item.req.sample = s;
      row_item.typed = typed;
      row_item.result.value = v;
      row_item.result.sat = sat;
      return row_item;
   endfunction

   function automatic stencil_req_type random_req();
      stencil_req_type r;
      r.func = 2'($urandom_range(3));
      r.col = 6'($urandom_range(63));
      r.row = 6'($urandom_range(63));
      r.direction = 2'($urandom_range(3));
      r.halo_index = 6'($urandom_range(63));
      r.sample = $urandom();
      return r;
   endfunction

   // Coordinates lean toward the tile edges where the halo is used.
   function automatic int pick_coord();
      int edges [4] = '{0, 1, GRID_X - 2, GRID_X - 1};
      if ($urandom_range(99) < 35)
         return edges[$urandom_range(3)];
      return $urandom_range(GRID_X - 1);
   endfunction

   function automatic logic signed [31:0] pick_sample();
      logic [31:0] s;
      s = $urandom();
      case ($urandom_range(5))
         0: return SAMPLE_MAX;
         1: return SAMPLE_MIN;
         2, 3: return {{14{s[17]}}, s[17:0]};
         default: return s;
      endcase
   endfunction

   // Present one item and hold it until the transfer; the sender may idle first.
   task automatic drive_item(input stencil_req_type it, input bit typed,
                             input stencil_result_type typed_res);
      stencil_result_type res;
      stencil_req_type junk;
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         junk = random_req();
         req_valid <= 1'b0;
         req_func <= junk.func;
         req_sample <= junk.sample;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_func <= it.func;
      req_col <= it.col;
      req_row <= it.row;
      req_direction <= it.direction;
      req_halo_index <= it.halo_index;
      req_sample <= it.sample;
      do @(posedge clock); while (req_stall);
      if (stencil_eval(it, res))
         stencil_expected.push_back(typed ? typed_res : res);
   endtask

   // Stop sending and wait until every expected result has come back.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (stencil_expected.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_gain(input logic signed [31:0] v);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= v;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      gain_shadow = v;
   endtask

   // Load one stencil operand if it was never loaded, or now and then anew.
   task automatic refresh_operand(input bit on_halo, input int side, input int a,
                                  input int b, inout int sent);
      stencil_req_type r;
      bit loaded;
      loaded = on_halo ? halo_loaded[halo_at(side, a)] : grid_loaded[grid_at(a, b)];
      if (!loaded || $urandom_range(99) < 25) begin
         r = random_req();
         r.sample = pick_sample();
         if (on_halo) begin
            r.func = FUNC_LOAD_HALO;
            r.direction = 2'(side);
            r.halo_index = 6'(a);
         end else begin
            r.func = FUNC_LOAD_GRID;
            r.col = 6'(a);
            r.row = 6'(b);
         end
         drive_item(r, 1'b0, '0);
         sent++;
      end
   endtask

   // One phase of random traffic under a fresh gain and idling mix.
   task automatic run_phase(input logic signed [31:0] gain, input int send_pct,
                            input int recv_pct, input int items, input int pause_at);
      stencil_req_type r;
      int sent;
      int x;
      int y;
      int pick;
      bit paused;
      sent = 0;
      paused = 1'b0;
      drain();
      repeat (SETTLE) @(posedge clock);
      write_gain(gain);
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      while (sent < items) begin
         if (pause_at > 0 && !paused && sent >= pause_at) begin
            drain();
            paused = 1'b1;
         end
         pick = $urandom_range(99);
         if (pick < 55) begin
            // Query with every operand loaded beforehand.
            x = pick_coord();
            y = pick_coord();
            refresh_operand(1'b0, 0, x, y, sent);
            if (x == GRID_X - 1) refresh_operand(1'b1, SIDE_PLUS_X, y, 0, sent);
            else refresh_operand(1'b0, 0, x + 1, y, sent);
            if (x == 0) refresh_operand(1'b1, SIDE_MINUS_X, y, 0, sent);
            else refresh_operand(1'b0, 0, x - 1, y, sent);
            if (y == GRID_Y - 1) refresh_operand(1'b1, SIDE_PLUS_Y, x, 0, sent);
            else refresh_operand(1'b0, 0, x, y + 1, sent);
            if (y == 0) refresh_operand(1'b1, SIDE_MINUS_Y, x, 0, sent);
            else refresh_operand(1'b0, 0, x, y - 1, sent);
            r = random_req();
            r.func = FUNC_QUERY;
            r.col = 6'(x);
            r.row = 6'(y);
            drive_item(r, 1'b0, '0);
            sent++;
         end else if (pick < 77) begin
            r = random_req();
            r.func = FUNC_LOAD_GRID;
            r.col = 6'(pick_coord());
            r.row = 6'(pick_coord());
            r.sample = pick_sample();
            drive_item(r, 1'b0, '0);
            sent++;
         end else if (pick < 95) begin
            r = random_req();
            r.func = FUNC_LOAD_HALO;
            r.halo_index = 6'(pick_coord());
            r.sample = pick_sample();
            drive_item(r, 1'b0, '0);
            sent++;
         end else begin
            // Ignored function code; it does not count toward the phase.
            r = random_req();
            r.func = FUNC_UNUSED;
            drive_item(r, 1'b0, '0);
         end
      end
   endtask

   // Receiver stall, changed at the falling edge.
   always @(negedge clock)
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);

   // Compare each result transfer with the oldest expectation.
   always @(posedge clock) begin
      stencil_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (stencil_expected.size() == 0) begin
            $display("%0t: result with nothing expected: value %h saturated %b",
                     $time, rsp_stencil_value, rsp_saturated);
            fail_count++;
         end else begin
            want = stencil_expected.pop_front();
            if (rsp_stencil_value !== want.value) begin
               $display("%0t: stencil_value expected %h actual %h",
                        $time, want.value, rsp_stencil_value);
               fail_count++;
            end
            if (rsp_saturated !== want.sat) begin
               $display("%0t: saturated expected %b actual %b",
                        $time, want.sat, rsp_saturated);
               fail_count++;
            end
         end
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      req_valid = 1'b0;
      req_func = FUNC_LOAD_GRID;
      req_col = '0;
      req_row = '0;
      req_direction = SIDE_PLUS_X;
      req_halo_index = '0;
      req_sample = '0;
      gain_shadow = GAIN_RESET;
      foreach (grid_shadow[i]) begin
         grid_shadow[i] = '0;
         grid_loaded[i] = 1'b0;
      end
      foreach (halo_shadow[i]) begin
         halo_shadow[i] = '0;
         halo_loaded[i] = 1'b0;
      end

      // Directed items at the reset gain of 4.0. Expected values are typed in
      // where they are plain to see.
      directed_rows.push_back(mk_row(FUNC_LOAD_GRID, 0, 0, 0, 0, 32'sh0, 0, 0, 0));
      directed_rows.push_back(mk_row(FUNC_LOAD_GRID, 1, 0, 3, 63, 32'sh0, 0, 0, 0));
      directed_rows.push_back(mk_row(FUNC_LOAD_GRID, 0, 1, 2, 21, 32'sh0, 0, 0, 0));
      directed_rows.push_back(mk_row(FUNC_LOAD_HALO, 63, 63, SIDE_MINUS_X, 0, 32'sh0,
                                     0, 0, 0));
      directed_rows.push_back(mk_row(FUNC_LOAD_HALO, 42, 7, SIDE_MINUS_Y, 0, 32'sh0,
                                     0, 0, 0));
      directed_rows.push_back(mk_row(FUNC_QUERY, 0, 0, 0, 0, 32'sh0, 1, 32'sh0, 0));
      // Center at the largest sample saturates high.
      directed_rows.push_back(mk_row(FUNC_LOAD_GRID, 0, 0, 0, 0, SAMPLE_MAX, 0, 0, 0));
      directed_rows.push_back(mk_row(FUNC_QUERY, 0, 0, 3, 63, 32'shffffffff, 1,
                                     SAMPLE_MAX, 1));
      // Center at the smallest sample saturates low.
      directed_rows.push_back(mk_row(FUNC_LOAD_GRID, 0, 0, 0, 0, SAMPLE_MIN, 0, 0, 0));
      directed_rows.push_back(mk_row(FUNC_QUERY, 0, 0, 0, 0, 32'sh0, 1, SAMPLE_MIN, 1));
      // 4 * 1.0 minus a halo neighbor of 1.0 gives 3.0.
      directed_rows.push_back(mk_row(FUNC_LOAD_GRID, 0, 0, 0, 0, 32'sh10000, 0, 0, 0));
      directed_rows.push_back(mk_row(FUNC_LOAD_HALO, 0, 0, SIDE_MINUS_X, 0, 32'sh10000,
                                     0, 0, 0));
      directed_rows.push_back(mk_row(FUNC_QUERY, 0, 0, 0, 0, 32'sh0, 1, 32'sh30000, 0));
      // Opposite corner: a center of minus one unit gives four times that.
      directed_rows.push_back(mk_row(FUNC_LOAD_GRID, 63, 63, 0, 0, 32'shffffffff, 0, 0, 0));
      directed_rows.push_back(mk_row(FUNC_LOAD_GRID, 62, 63, 0, 0, 32'sh0, 0, 0, 0));
      directed_rows.push_back(mk_row(FUNC_LOAD_GRID, 63, 62, 0, 0, 32'sh0, 0, 0, 0));
      directed_rows.push_back(mk_row(FUNC_LOAD_HALO, 0, 0, SIDE_PLUS_X, 63, 32'sh0,
                                     0, 0, 0));
      directed_rows.push_back(mk_row(FUNC_LOAD_HALO, 0, 0, SIDE_PLUS_Y, 63, 32'sh0,
                                     0, 0, 0));
      directed_rows.push_back(mk_row(FUNC_QUERY, 63, 63, 1, 5, 32'sh0, 1,
                                     32'shfffffffc, 0));
      // Unused function code with every field at all ones.
      directed_rows.push_back(mk_row(FUNC_UNUSED, 63, 63, 3, 63, 32'shffffffff, 0, 0, 0));
      // Halo neighbors at both extremes, checked by the predictor.
      directed_rows.push_back(mk_row(FUNC_LOAD_HALO, 0, 0, SIDE_PLUS_X, 63, SAMPLE_MAX,
                                     0, 0, 0));
      directed_rows.push_back(mk_row(FUNC_LOAD_HALO, 0, 0, SIDE_PLUS_Y, 63, SAMPLE_MIN,
                                     0, 0, 0));
      directed_rows.push_back(mk_row(FUNC_QUERY, 63, 63, 0, 0, 32'sh0, 0, 0, 0));

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         drive_item(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].result);

      // Random phases: gain extremes and the different idling mixes.
      run_phase(SAMPLE_MIN, 0, 0, 100, 0);
      run_phase(SAMPLE_MAX, 52, 0, 100, 55);
      run_phase(32'sh0, 0, 52, 100, 0);
      run_phase($urandom(), 31, 31, 100, 0);
      run_phase(GAIN_RESET + $urandom_range(32'h3ffff), 0, 0, 100, 0);

      drain();
      repeat (SETTLE) @(posedge clock);
      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

`default_nettype wire

>>> files.f
rtl/core/lsh_pkg.sv
rtl/core/lsh_front.sv
rtl/core/lsh_queue.sv
rtl/core/lsh_back.sv
rtl/core/laplacian_stencil_with_halo_core.sv
tb/testbench.sv
